@@ hw/rtl/ccrb_pkg.sv @@
// ----------------------------------------------------------------------------
// ccrb_pkg: shared types and constants for the code point bitmap
// Kinds, parse phases, radix codes, character constants and classing functions.
// ----------------------------------------------------------------------------
package ccrb_pkg;
  localparam int unsigned MAX_POINTS_DEF = 65536;
  localparam int unsigned VALUE_BITS_DEF = 24;
  localparam int unsigned CFG_BITS       = 17;
  localparam int unsigned CP_BITS        = 21;

  localparam logic [2:0] KIND_SPEC  = 3'd0;
  localparam logic [2:0] KIND_END   = 3'd1;
  localparam logic [2:0] KIND_QUERY = 3'd2;
  localparam logic [2:0] KIND_CLR   = 3'd3;
  localparam logic [2:0] KIND_CLRALL = 3'd4;

  localparam logic [3:0] PH_LEAD   = 4'd0;
  localparam logic [3:0] PH_N1     = 4'd1;
  localparam logic [3:0] PH_N1HEX  = 4'd2;
  localparam logic [3:0] PH_N1DIG  = 4'd3;
  localparam logic [3:0] PH_AFTER1 = 4'd4;
  localparam logic [3:0] PH_DASH   = 4'd5;
  localparam logic [3:0] PH_N2     = 4'd6;
  localparam logic [3:0] PH_N2HEX  = 4'd7;
  localparam logic [3:0] PH_N2DIG  = 4'd8;
  localparam logic [3:0] PH_AFTER2 = 4'd9;
  localparam logic [3:0] PH_SKIP   = 4'd10;

  localparam logic [1:0] RADIX_DEC = 2'd0;
  localparam logic [1:0] RADIX_OCT = 2'd1;
  localparam logic [1:0] RADIX_HEX = 2'd2;

  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_SPACE = 8'd32;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_dec(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] v;
    if (c >= 8'h30 && c <= 8'h39) v = 5'(c - 8'h30);
    else if (c >= 8'h61 && c <= 8'h66) v = 5'(c - 8'h61 + 8'd10);
    else if (c >= 8'h41 && c <= 8'h46) v = 5'(c - 8'h41 + 8'd10);
    else v = 5'd16;
    return v;
  endfunction
endpackage

@@ hw/rtl/ccrb_parser.sv @@
// ----------------------------------------------------------------------------
// ccrb_parser: range list parser
// Steps the parse state over one spec byte per step; a step may hand off a
// fill request and then be repeated for the same byte (reprocess).
// ----------------------------------------------------------------------------
module ccrb_parser import ccrb_pkg::*; #(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,      // apply one step
  input  logic                  is_end,    // end-of-spec step
  input  logic [7:0]            ch,
  output logic                  again,     // byte must be processed again
  output logic                  err,
  output logic                  fill,
  output logic [VALUE_BITS-1:0] fill_lo,
  output logic [VALUE_BITS-1:0] fill_hi,
  output logic                  mul_go,    // accumulate through shared unit
  output logic [4:0]            mul_d,
  input  logic                  mul_done,
  input  logic [VALUE_BITS-1:0] mul_q,
  output logic [VALUE_BITS-1:0] accum,
  output logic [1:0]            radix
);
  logic [3:0]            phase, phase_next;
  logic [VALUE_BITS-1:0] rstart, rstart_next, accum_next;
  logic [1:0]            radix_next;
  logic [4:0]            hv, rd;
  logic                  nb_n2;

  always_comb begin
    hv = hex_val(ch);
    rd = hv;
    if (radix == RADIX_DEC && hv > 5'd9) rd = 5'd16;
    if (radix == RADIX_OCT && hv > 5'd7) rd = 5'd16;
    nb_n2 = phase >= PH_N2;
    phase_next = phase; rstart_next = rstart; accum_next = accum; radix_next = radix;
    again = 1'b0; err = 1'b0; fill = 1'b0; fill_lo = rstart; fill_hi = rstart;
    mul_go = 1'b0; mul_d = rd;
    if (mul_done) accum_next = mul_q;
    if (step && is_end) begin
      unique case (phase)
        PH_N1HEX: begin fill = 1'b1; fill_lo = '0; fill_hi = '0; err = 1'b1; end
        PH_N1, PH_N1DIG: begin fill = 1'b1; fill_lo = accum; fill_hi = accum; end
        PH_AFTER1: fill = 1'b1;
        PH_DASH: begin fill = 1'b1; err = 1'b1; end
        PH_N2HEX: begin fill = 1'b1; fill_hi = '0; err = 1'b1; end
        PH_N2, PH_N2DIG: begin fill = 1'b1; fill_hi = accum; end
        default: ;
      endcase
      phase_next = PH_LEAD; rstart_next = '0; accum_next = '0; radix_next = RADIX_DEC;
    end else if (step) begin
      unique case (phase)
        PH_LEAD, PH_AFTER2: begin
          if (is_ws(ch)) ;
          else if (phase == PH_AFTER2 && ch == CH_COMMA) phase_next = PH_LEAD;
          else if (is_dec(ch)) begin
            accum_next = '0;
            if (ch == 8'h30) begin radix_next = RADIX_OCT; phase_next = PH_N1; end
            else begin
              radix_next = RADIX_DEC; phase_next = PH_N1DIG;
              accum_next = VALUE_BITS'(hv);
            end
          end else begin phase_next = PH_SKIP; err = 1'b1; end
        end
        PH_N1, PH_N1HEX, PH_N1DIG, PH_N2, PH_N2HEX, PH_N2DIG: begin
          if (phase == PH_N1HEX || phase == PH_N2HEX) begin
            if (hv < 5'd16) begin
              accum_next = VALUE_BITS'(hv);
              phase_next = nb_n2 ? PH_N2DIG : PH_N1DIG;
            end else begin
              fill = 1'b1; fill_hi = '0;
              if (!nb_n2) fill_lo = '0;
              phase_next = PH_SKIP; err = 1'b1;
            end
          end else if ((phase == PH_N1 || phase == PH_N2) && (ch == 8'h78 || ch == 8'h58))
          begin
            radix_next = RADIX_HEX;
            phase_next = nb_n2 ? PH_N2HEX : PH_N1HEX;
          end else if (rd < 5'd16) begin
            mul_go = 1'b1;
            phase_next = nb_n2 ? PH_N2DIG : PH_N1DIG;
          end else if (!nb_n2) begin
            rstart_next = accum; phase_next = PH_AFTER1; again = 1'b1;
          end else begin
            fill = 1'b1; fill_hi = accum; phase_next = PH_AFTER2; again = 1'b1;
          end
        end
        PH_AFTER1: begin
          if (is_ws(ch)) ;
          else if (ch == CH_DASH) phase_next = PH_DASH;
          else begin fill = 1'b1; phase_next = PH_AFTER2; again = 1'b1; end
        end
        PH_DASH: begin
          if (is_ws(ch)) ;
          else if (is_dec(ch)) begin
            accum_next = '0;
            if (ch == 8'h30) begin radix_next = RADIX_OCT; phase_next = PH_N2; end
            else begin
              radix_next = RADIX_DEC; phase_next = PH_N2DIG;
              accum_next = VALUE_BITS'(hv);
            end
          end else begin fill = 1'b1; phase_next = PH_SKIP; err = 1'b1; end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_LEAD; rstart <= '0; accum <= '0; radix <= RADIX_DEC;
    end else begin
      phase <= phase_next; rstart <= rstart_next; accum <= accum_next; radix <= radix_next;
    end
  end
endmodule

@@ hw/rtl/ccrb_alu.sv @@
// ----------------------------------------------------------------------------
// ccrb_alu: shared accumulate unit
// Registers accum * radix + digit, saturated, in the cycle after a start.
// ----------------------------------------------------------------------------
module ccrb_alu import ccrb_pkg::*; #(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  go,
  input  logic [VALUE_BITS-1:0] a,
  input  logic [1:0]            radix,
  input  logic [4:0]            d,
  output logic                  done,
  output logic [VALUE_BITS-1:0] q
);
  logic [VALUE_BITS+4:0] prod;
  always_comb begin
    unique case (radix)
      RADIX_HEX: prod = ({5'd0, a} << 4) + (VALUE_BITS+5)'(d);
      RADIX_OCT: prod = ({5'd0, a} << 3) + (VALUE_BITS+5)'(d);
      default:   prod = ({5'd0, a} << 3) + ({5'd0, a} << 1) + (VALUE_BITS+5)'(d);
    endcase
  end
  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= go;
    q <= (prod[VALUE_BITS+4:VALUE_BITS] != '0) ? '1 : prod[VALUE_BITS-1:0];
  end
endmodule

@@ hw/rtl/char_class_range_bitmap.sv @@
// Path: an out-of-range query or unknown kind goes straight to the result beat; a
// query reads its word; spec and end bytes pass a parser step, a further digit the
// accumulate unit, a point clear a read and write of its word, a range fill a read
// and write per covered word, then the byte again if asked; clear-all writes all.
// Throughput: one item at a time; input reopens the cycle after the result beat.
// Reset: the map is swept clear word by word, no item accepted until it is done.
// ----------------------------------------------------------------------------
// char_class_range_bitmap: code point bitmap built from a range list
// A sequencer steps the parser, the shared accumulate unit and a word walk
// over the bitmap memory (read, modify, write each word; a clear-all only writes).
// ----------------------------------------------------------------------------
module char_class_range_bitmap import ccrb_pkg::*; #(
  parameter int unsigned MAX_POINTS = MAX_POINTS_DEF,
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [CFG_BITS-1:0] cfg_wdata,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [2:0]          kind,
  input  logic [7:0]          spec_char,
  input  logic [CP_BITS-1:0]  code_point,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                is_member,
  output logic                spec_error
);
  localparam int unsigned WORDS = (MAX_POINTS + 31) / 32;
  localparam int unsigned AW = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int unsigned SW = $clog2(MAX_POINTS + 1);

  typedef enum logic [7:0] {
    S_SWEEP = 8'b00000001, S_IDLE = 8'b00000010, S_PARSE = 8'b00000100,
    S_MUL   = 8'b00001000, S_RD   = 8'b00010000, S_WR    = 8'b00100000,
    S_Q     = 8'b01000000, S_OUT  = 8'b10000000
  } state_t;

  state_t state;
  logic [CFG_BITS-1:0]   num_points;
  logic [2:0]            k;
  logic [7:0]            ch;
  logic [CP_BITS-1:0]    cp;
  logic [SW-1:0]         lim;
  logic [AW-1:0]         waddr, wlast;
  logic [4:0]            lo_bit, hi_bit;
  logic                  first;
  logic [31:0]           mem [WORDS];
  logic [31:0]           rdata;
  logic                  err_acc;
  logic                  clr_all;
  logic                  p_again_q;

  // parser hookup
  logic                  p_step, p_again, p_err, p_fill, m_go, m_done;
  logic [VALUE_BITS-1:0] f_lo, f_hi, accum, m_q;
  logic [1:0]            radix;
  logic [4:0]            m_d;

  assign lim = (32'(num_points) > 32'(MAX_POINTS)) ? SW'(MAX_POINTS) : SW'(num_points);
  assign in_stall = (state != S_IDLE);
  assign p_step = (state == S_PARSE);

  ccrb_parser #(.VALUE_BITS(VALUE_BITS)) u_parser (
    .clk, .rst, .step(p_step), .is_end(k == KIND_END), .ch, .again(p_again),
    .err(p_err), .fill(p_fill), .fill_lo(f_lo), .fill_hi(f_hi), .mul_go(m_go),
    .mul_d(m_d), .mul_done(m_done), .mul_q(m_q), .accum, .radix);

  ccrb_alu #(.VALUE_BITS(VALUE_BITS)) u_alu (
    .clk, .rst, .go(m_go), .a(accum), .radix, .d(m_d), .done(m_done), .q(m_q));

  // clipped fill bounds, valid only when fill_ok
  logic                  fill_ok;
  logic [VALUE_BITS-1:0] hi_c;
  always_comb begin
    fill_ok = (lim != '0) && (f_lo <= f_hi) && ({8'd0, f_lo} < 32'(lim));
    hi_c = ({8'd0, f_hi} >= 32'(lim)) ? VALUE_BITS'(lim - SW'(1)) : f_hi;
  end

  logic [31:0] mask;
  always_comb begin
    mask = '1;
    if (!clr_all) begin
      if (k == KIND_CLR) mask = ~(32'd1 << lo_bit);
      else begin
        if (first) mask = mask & ('1 << lo_bit);
        if (waddr == wlast) mask = mask & ('1 >> (5'd31 - hi_bit));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_RD || state == S_Q) rdata <= mem[waddr];
    if (state == S_SWEEP || (state == S_WR && clr_all)) mem[waddr] <= '0;
    else if (state == S_WR && k == KIND_CLR) mem[waddr] <= rdata & mask;
    else if (state == S_WR) mem[waddr] <= rdata | mask;
  end

  always_ff @(posedge clk) begin
    if (rst) num_points <= CFG_BITS'(65536);
    else if (cfg_we) num_points <= cfg_wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_SWEEP; waddr <= '0; out_valid <= 1'b0; clr_all <= 1'b0;
    end else begin
      unique case (state)
        S_SWEEP: begin
          waddr <= waddr + AW'(1);
          if (waddr == AW'(WORDS - 1)) state <= S_IDLE;
        end
        S_IDLE: if (in_valid) begin
          k <= kind; ch <= spec_char; cp <= code_point;
          err_acc <= 1'b0; is_member <= 1'b0; clr_all <= 1'b0;
          if (kind == KIND_SPEC || kind == KIND_END) state <= S_PARSE;
          else if (kind == KIND_QUERY) begin
            waddr <= AW'(code_point >> 5); lo_bit <= code_point[4:0];
            state <= ({11'd0, code_point} >= 32'(lim)) ? S_OUT : S_Q;
            is_member <= 1'b1;
          end else if (kind == KIND_CLR) begin
            waddr <= AW'(code_point >> 5); lo_bit <= code_point[4:0];
            state <= ({11'd0, code_point} < 32'(lim)) ? S_RD : S_OUT;
          end else if (kind == KIND_CLRALL) begin
            waddr <= '0; wlast <= AW'(WORDS - 1); clr_all <= 1'b1; state <= S_WR;
          end else state <= S_OUT;
        end
        S_PARSE: begin
          err_acc <= err_acc | p_err;
          if (p_fill && fill_ok) begin
            waddr <= AW'(f_lo >> 5); wlast <= AW'(hi_c >> 5);
            lo_bit <= f_lo[4:0]; hi_bit <= hi_c[4:0]; first <= 1'b1;
            state <= S_RD;
          end else if (m_go) state <= S_MUL;
          else if (!p_again) state <= S_OUT;
        end
        S_MUL: state <= S_OUT;
        S_RD: state <= S_WR;
        S_WR: begin
          // advance word walk, then resume the byte if the parser asked
          first <= 1'b0;
          if (waddr == wlast || k == KIND_CLR) state <= (p_again_q) ? S_PARSE : S_OUT;
          else begin
            waddr <= waddr + AW'(1);
            state <= clr_all ? S_WR : S_RD;
          end
        end
        S_Q: state <= S_OUT;
        S_OUT: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
            spec_error <= err_acc;
            if (k == KIND_QUERY && is_member && !(32'(lim) <= {11'd0, cp}))
              is_member <= rdata[cp[4:0]];
          end else if (!out_stall) begin
            out_valid <= 1'b0; state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // remember whether a fill interrupted a byte that must be processed again
  always_ff @(posedge clk) begin
    if (rst) p_again_q <= 1'b0;
    else if (state == S_PARSE) p_again_q <= p_again;
  end

`ifndef NO_ASSERTIONS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> in_stall) else $error("accept while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(is_member) && $stable(spec_error)))
    else $error("result changed while stalled");
  a_out_only_done: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (state == S_OUT)) else $error("result outside output state");
`endif
endmodule
